>>> src/vdmc_pkg.sv
// Shared types and codes for the vehicle drive mode controller.
package vdmc_pkg;

    localparam int DIST_W = 12;
    localparam int KEY_W  = 8;
    localparam int CFG_W  = 12;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_LKAS         = 3'd1,
        MODE_LKAS_STOPPED = 3'd2,
        MODE_LANE_CHANGE  = 3'd3,
        MODE_SIGN_TURN    = 3'd4,
        MODE_MANUAL       = 3'd5,
        MODE_EMERGENCY    = 3'd6,
        MODE_PARK         = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        LK_NONE       = 3'd0,
        LK_START      = 3'd1,
        LK_STOP       = 3'd2,
        LK_RUN        = 3'd3,
        LK_RUN_CRUISE = 3'd4
    } lk_cmd_t;

    localparam logic [1:0] MAN_NONE        = 2'd0;
    localparam logic [1:0] MAN_LANE_CHANGE = 2'd1;
    localparam logic [1:0] MAN_SIGN_TURN   = 2'd2;

    localparam logic [0:0] CFG_ACC_ON_BELOW  = 1'b0;
    localparam logic [0:0] CFG_ACC_OFF_ABOVE = 1'b1;

    localparam logic [CFG_W-1:0] ACC_ON_BELOW_RST  = 12'd300;
    localparam logic [CFG_W-1:0] ACC_OFF_ABOVE_RST = 12'd500;

    localparam logic [KEY_W-1:0] KEY_LANE_KEEP = 8'h6C; // 'l'
    localparam logic [KEY_W-1:0] KEY_PARK      = 8'h70; // 'p'
    localparam logic [KEY_W-1:0] KEY_ONE       = 8'h31; // '1'
    localparam logic [KEY_W-1:0] KEY_TWO       = 8'h32; // '2'
    localparam logic [KEY_W-1:0] KEY_THREE     = 8'h33; // '3'
    localparam logic [KEY_W-1:0] KEY_NINE      = 8'h39; // '9'

    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic              brake_request;
        logic              obstacle_timeout;
        logic              red_sign;
        logic [KEY_W-1:0]  key_code;
    } tick_t;

    typedef struct packed {
        logic       clear_red_sign;
        logic       clear_obstacle;
        logic       park_cmd;
        logic       leds_off;
        logic       sound_alarm;
        logic       manual_cmd;
        logic [1:0] maneuver;
        logic       start_timeout;
        logic       brake;
        lk_cmd_t    lane_keep_cmd;
        mode_t      mode;
    } cmd_t;

endpackage

>>> src/vehicle_drive_mode_controller.sv
// Vehicle drive mode controller: tick decode, mode state machine and command register.
//
// Usage: each word on the s_ channel is one control tick carrying the forward
// distance, the emergency brake flag, the obstacle timeout flag, the red sign
// flag and the last key. For every tick the block returns exactly one command
// word on the m_ channel: the new drive mode plus one-tick commands for the
// lane keeper, brakes, timers, maneuvers, manual drive, alarm, LEDs and park.
// The two cruise thresholds are written through cfg_we/cfg_addr/cfg_wdata; the
// user must do so only while no tick is in flight (the block does not enforce it).
// Path: an accepted tick is held in the input register and decided from there;
// its command word is written into the command register, which drives m_tvalid.
// Throughput: one tick per cycle while the receiver does not stall; the mode decision
// between the input register and the command register is the only loop.
// Reset (aresetn low, synchronous) empties both registers, sets the mode to
// idle, clears the cruise enable, arms the alarm and loads the threshold
// defaults of 300 mm and 500 mm.
// When the receiver stalls the command word holds; one more tick may sit in
// the input register, after which s_tready drops until m_tready returns.
module vehicle_drive_mode_controller
    import vdmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] distance_mm, [12] brake_request, [13] obstacle_timeout,
    // [14] red_sign, [22:15] key_code, [23] unused
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] mode, [5:3] lane_keep_cmd, [6] brake, [7] start_timeout,
    // [9:8] maneuver, [10] manual_cmd, [11] sound_alarm, [12] leds_off,
    // [13] park_cmd, [14] clear_obstacle, [15] clear_red_sign
    output logic [15:0] m_tdata
);

    logic [CFG_W-1:0] acc_on_below_reg;
    logic [CFG_W-1:0] acc_off_above_reg;
    logic             in_valid_reg;
    tick_t            tick_reg;
    logic             out_valid_reg;
    cmd_t             cmd_reg;
    mode_t            mode_reg;
    mode_t            mode_next;
    logic             cruise_reg;
    logic             cruise_next;
    logic             armed_reg;
    logic             armed_next;
    mode_t            eff_mode;
    cmd_t             cmd_next;
    logic             advance;
    logic             rev_key;
    logic             digit_key;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cmd_reg;

    assign rev_key   = (tick_reg.key_code == KEY_ONE) || (tick_reg.key_code == KEY_TWO)
                       || (tick_reg.key_code == KEY_THREE);
    assign digit_key = (tick_reg.key_code >= KEY_ONE) && (tick_reg.key_code <= KEY_NINE);
    assign eff_mode  = tick_reg.red_sign ? MODE_SIGN_TURN : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_on_below_reg  <= ACC_ON_BELOW_RST;
            acc_off_above_reg <= ACC_OFF_ABOVE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ACC_ON_BELOW:  acc_on_below_reg  <= cfg_wdata;
                CFG_ACC_OFF_ABOVE: acc_off_above_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg.distance_mm      <= s_tdata[11:0];
            tick_reg.brake_request    <= s_tdata[12];
            tick_reg.obstacle_timeout <= s_tdata[13];
            tick_reg.red_sign         <= s_tdata[14];
            tick_reg.key_code         <= s_tdata[22:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            cruise_reg    <= 1'b0;
            armed_reg     <= 1'b1;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                cruise_reg    <= cruise_next;
                armed_reg     <= armed_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cmd_reg <= cmd_next;
        end
    end

    // next state
    always_comb begin
        mode_next = eff_mode;
        unique case (eff_mode)
            MODE_LKAS: begin
                if (tick_reg.brake_request) begin
                    mode_next = MODE_LKAS_STOPPED;
                end
            end
            MODE_LKAS_STOPPED: begin
                if (tick_reg.obstacle_timeout) begin
                    mode_next = MODE_LANE_CHANGE;
                end else if (!tick_reg.brake_request) begin
                    mode_next = MODE_LKAS;
                end
            end
            MODE_LANE_CHANGE: mode_next = MODE_LKAS;
            MODE_SIGN_TURN:   mode_next = MODE_IDLE;
            MODE_IDLE: begin
                if (tick_reg.key_code == KEY_LANE_KEEP) begin
                    mode_next = MODE_LKAS;
                end else if (digit_key) begin
                    mode_next = MODE_MANUAL;
                end else if (tick_reg.key_code == KEY_PARK) begin
                    mode_next = MODE_PARK;
                end
            end
            MODE_MANUAL: begin
                if (tick_reg.brake_request && !rev_key) begin
                    mode_next = MODE_EMERGENCY;
                end
            end
            MODE_EMERGENCY: begin
                if (rev_key) begin
                    mode_next = MODE_MANUAL;
                end else if (!tick_reg.brake_request) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_PARK: mode_next = MODE_IDLE;
            default:   mode_next = MODE_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd_next      = '0;
        cmd_next.mode = mode_next;
        cruise_next   = cruise_reg;
        armed_next    = armed_reg;
        if (tick_reg.red_sign && ((mode_reg == MODE_LKAS) || (mode_reg == MODE_LKAS_STOPPED)
                                  || (mode_reg == MODE_LANE_CHANGE))) begin
            cmd_next.lane_keep_cmd = LK_STOP;
        end
        unique case (eff_mode)
            MODE_LKAS: begin
                if (tick_reg.brake_request) begin
                    cmd_next.lane_keep_cmd = LK_STOP;
                    cmd_next.brake         = 1'b1;
                    cmd_next.start_timeout = 1'b1;
                end else begin
                    if (tick_reg.distance_mm < acc_on_below_reg) begin
                        cruise_next = 1'b1;
                    end else if (tick_reg.distance_mm > acc_off_above_reg) begin
                        cruise_next = 1'b0;
                    end
                    cmd_next.lane_keep_cmd = cruise_next ? LK_RUN_CRUISE : LK_RUN;
                end
            end
            MODE_LKAS_STOPPED: begin
                if (!tick_reg.brake_request) begin
                    cmd_next.lane_keep_cmd = LK_START;
                end
            end
            MODE_LANE_CHANGE: begin
                cmd_next.maneuver       = MAN_LANE_CHANGE;
                cmd_next.clear_obstacle = 1'b1;
                cmd_next.lane_keep_cmd  = LK_START;
            end
            MODE_SIGN_TURN: begin
                cmd_next.maneuver       = MAN_SIGN_TURN;
                cmd_next.clear_red_sign = 1'b1;
            end
            MODE_IDLE: begin
                if (tick_reg.key_code == KEY_LANE_KEEP) begin
                    cmd_next.lane_keep_cmd = LK_START;
                end
            end
            MODE_MANUAL: begin
                if (!(tick_reg.brake_request && !rev_key)) begin
                    cmd_next.manual_cmd = 1'b1;
                end
            end
            MODE_EMERGENCY: begin
                cmd_next.brake       = 1'b1;
                cmd_next.sound_alarm = armed_reg;
                armed_next           = 1'b0;
                if (rev_key || !tick_reg.brake_request) begin
                    armed_next        = 1'b1;
                    cmd_next.leds_off = 1'b1;
                end
            end
            MODE_PARK: cmd_next.park_cmd = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_alarm_brakes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cmd_reg.sound_alarm) |-> cmd_reg.brake)
        else $error("alarm issued without brake");

    a_leds_off_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cmd_reg.leds_off) |->
            ((cmd_reg.mode == MODE_MANUAL) || (cmd_reg.mode == MODE_IDLE)))
        else $error("leds off outside emergency exit");

    a_sign_turn_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cmd_reg.clear_red_sign) |->
            ((cmd_reg.mode == MODE_IDLE) && (cmd_reg.maneuver == MAN_SIGN_TURN)))
        else $error("sign turn did not return to idle");

    a_timeout_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cmd_reg.start_timeout) |->
            ((cmd_reg.mode == MODE_LKAS_STOPPED) && (cmd_reg.lane_keep_cmd == LK_STOP)))
        else $error("timeout start outside lanekeep stop");
`endif

endmodule
